// ===== design/heartbeat_keepalive_monitor_macros.svh =====
// Assertion macros used by the heartbeat keepalive monitor checker.
`ifndef HEARTBEAT_KEEPALIVE_MONITOR_MACROS_SVH
`define HEARTBEAT_KEEPALIVE_MONITOR_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define HKM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define HKM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hkm_pkg.sv =====
// Package with the types, codes and constants of the heartbeat keepalive monitor.
package hkm_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_RX_PKT  = 3'd1;
    localparam logic [2:0] REQ_UP_SEND = 3'd2;
    localparam logic [2:0] REQ_SET_RT  = 3'd3;
    localparam logic [2:0] REQ_BAD_PKT = 3'd4;

    // Error codes of a result word.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_RX_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_RX_WARN    = 2'd2;
    localparam logic [1:0] ERR_BAD_PKT    = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SLAVE_MODE = 1'b0;
    localparam logic CFG_HB_ENABLE  = 1'b1;

    // Timer defaults and limits, in seconds.
    localparam logic [31:0] DEF_WRITE_LIMIT = 32'd60;
    localparam logic [31:0] DEF_READ_LIMIT  = 32'd120;
    localparam logic [31:0] DEF_WARN_LIMIT  = 32'd80;
    localparam logic [31:0] MIN_READ_LIMIT  = 32'd4;
    localparam logic [7:0]  CTRL_EXT_LEN    = 8'd4;

    // ceil(2^33 / 3): (x * DIV3_RECIP) >> 33 equals x / 3 for any 32-bit x.
    localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 72;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now;
        logic        is_timeout_ctrl;
        logic [7:0]  ext_len;
        logic [31:0] ext_value;
        logic [31:0] new_read_timeout;
    } t_item;

    typedef struct packed {
        logic slave_mode;
        logic heartbeat_enable;
    } t_cfg;

    // Decisions of the state stage, handed to the output stage.
    typedef struct packed {
        logic        deliver_up;
        logic        send_keepalive;
        logic        send_timeout_ctrl;
        logic [1:0]  error_code;
        logic [31:0] warn_elapsed;
        logic [31:0] div_arg;
    } t_mid;

    typedef struct packed {
        logic        deliver_up;
        logic        send_keepalive;
        logic        send_timeout_ctrl;
        logic [31:0] timeout_value;
        logic [1:0]  error_code;
        logic [31:0] warn_elapsed;
    } t_result;

endpackage

// ===== design/heartbeat_keepalive_monitor.sv =====
// Top level of the heartbeat keepalive monitor: handshake, configuration and stage wiring.
// Path: a word accepted into the input register moves through the timer state stage, then
// the divide-by-three output stage, where it is held until the output side takes it.
// Throughput: one word per cycle while the output is not stalled; every event settles its
// timer state in the state stage, so the next event already sees the updated timers. Reset
// (synchronous, active low) empties the pipeline and restores timers and config registers.
module heartbeat_keepalive_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now[31:0], is_timeout_ctrl[32], ext_len[40:33], ext_value[72:41],
    // new_read_timeout[104:73], zero fill[111:105]
    input  logic [111:0] i_s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]   i_s_axis_tuser,

    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // deliver_up[0], send_keepalive[1], send_timeout_ctrl[2], timeout_value[34:3],
    // error_code[36:35], warn_elapsed[68:37], zero fill[71:69]
    output logic [71:0]  o_m_axis_tdata,

    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic         i_cfg_wdata
);
    import hkm_pkg::*;

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_v0, r_v1, r_v2;
    logic    rdy0, rdy1, rdy2;
    logic    load_item, load_core, load_out;
    t_mid    mid;
    t_result result;

    // Each stage can take a word when it is empty or when its word moves on.
    assign rdy2 = !r_v2 || i_m_axis_tready;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign load_item = i_s_axis_tvalid && rdy0;
    assign load_core = r_v0 && rdy1;
    assign load_out  = r_v1 && rdy2;

    assign o_s_axis_tready = rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= load_item || (r_v0 && !rdy1);
            r_v1 <= load_core || (r_v1 && !rdy2);
            r_v2 <= load_out  || (r_v2 && !i_m_axis_tready);
        end
    end

    // Input register: unpack the incoming word.
    always_ff @(posedge i_clk) begin
        if (load_item) begin
            r_item.req_type         <= i_s_axis_tuser;
            r_item.now              <= i_s_axis_tdata[31:0];
            r_item.is_timeout_ctrl  <= i_s_axis_tdata[32];
            r_item.ext_len          <= i_s_axis_tdata[40:33];
            r_item.ext_value        <= i_s_axis_tdata[72:41];
            r_item.new_read_timeout <= i_s_axis_tdata[104:73];
        end
    end

    // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_mode       <= 1'b0;
            r_cfg.heartbeat_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SLAVE_MODE: begin
                    r_cfg.slave_mode <= i_cfg_wdata;
                end
                CFG_HB_ENABLE: begin
                    r_cfg.heartbeat_enable <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    hkm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load_core),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_mid   (mid)
    );

    hkm_out u_out (
        .i_clk    (i_clk),
        .i_load   (load_out),
        .i_mid    (mid),
        .o_result (result)
    );

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = {3'd0, result.warn_elapsed, result.error_code,
                              result.timeout_value, result.send_timeout_ctrl,
                              result.send_keepalive, result.deliver_up};

endmodule

// ===== design/hkm_core.sv =====
// State stage: timer registers, timeout checks and read timeout updates.
module hkm_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  hkm_pkg::t_item i_item,
    input  hkm_pkg::t_cfg  i_cfg,
    output hkm_pkg::t_mid  o_mid
);
    import hkm_pkg::*;

    logic [31:0] r_last_read_time, n_last_read_time;
    logic [31:0] r_last_write_time, n_last_write_time;
    logic [31:0] r_last_warn_time, n_last_warn_time;
    logic [31:0] r_read_limit, n_read_limit;
    logic [31:0] r_write_limit, n_write_limit;
    logic [31:0] r_warn_limit, n_warn_limit;
    t_mid        r_mid, n_mid;

    logic [31:0] d_read, d_write, d_warn;
    logic [31:0] ext_x3, rt_req, rt_req_m1;
    logic        rt_low, do_apply;

    assign d_read  = i_item.now - r_last_read_time;
    assign d_write = i_item.now - r_last_write_time;
    assign d_warn  = i_item.now - r_last_warn_time;

    // A timeout-control packet in slave mode asks for a read timeout of 3*W+4.
    assign ext_x3    = {i_item.ext_value[30:0], 1'b0} + i_item.ext_value;
    assign rt_req    = (i_item.req_type == REQ_RX_PKT) ? ext_x3 + 32'd4
                                                       : i_item.new_read_timeout;
    assign rt_req_m1 = (i_item.req_type == REQ_RX_PKT) ? ext_x3 + 32'd3
                                                       : i_item.new_read_timeout - 32'd1;
    assign rt_low    = rt_req < MIN_READ_LIMIT;

    always_comb begin
        n_last_read_time  = r_last_read_time;
        n_last_write_time = r_last_write_time;
        n_last_warn_time  = r_last_warn_time;
        n_read_limit      = r_read_limit;
        n_write_limit     = r_write_limit;
        n_warn_limit      = r_warn_limit;
        n_mid             = '0;
        do_apply          = 1'b0;

        case (i_item.req_type)
            REQ_TICK: begin
                if (i_cfg.heartbeat_enable) begin
                    if (d_read > r_read_limit) begin
                        n_mid.error_code = ERR_RX_TIMEOUT;
                    end else begin
                        if (d_write >= r_write_limit) begin
                            n_mid.send_keepalive = 1'b1;
                            n_last_write_time    = i_item.now;
                        end
                        if (d_warn > r_warn_limit) begin
                            n_mid.error_code   = ERR_RX_WARN;
                            n_mid.warn_elapsed = d_warn;
                            n_last_warn_time   = i_item.now;
                        end
                    end
                end
            end
            REQ_RX_PKT: begin
                n_last_read_time = i_item.now;
                n_last_warn_time = i_item.now;
                if (!i_item.is_timeout_ctrl) begin
                    n_mid.deliver_up = 1'b1;
                end else if (i_item.ext_len == CTRL_EXT_LEN) begin
                    n_write_limit = i_item.ext_value;
                    do_apply      = i_cfg.slave_mode;
                end
            end
            REQ_UP_SEND: begin
                n_last_write_time = i_item.now;
            end
            REQ_SET_RT: begin
                do_apply = 1'b1;
            end
            REQ_BAD_PKT: begin
                n_mid.error_code = ERR_BAD_PKT;
            end
            default: begin
            end
        endcase

        // The warning limit follows the requested value before clamping.
        if (do_apply && (rt_req != r_read_limit)) begin
            n_read_limit            = rt_low ? MIN_READ_LIMIT : rt_req;
            n_warn_limit            = {1'b0, rt_req[31:1]};
            n_mid.send_timeout_ctrl = 1'b1;
            n_mid.div_arg           = rt_low ? MIN_READ_LIMIT - 32'd1 : rt_req_m1;
            n_last_write_time       = i_item.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_read_time  <= '0;
            r_last_write_time <= '0;
            r_last_warn_time  <= '0;
            r_read_limit      <= DEF_READ_LIMIT;
            r_write_limit     <= DEF_WRITE_LIMIT;
            r_warn_limit      <= DEF_WARN_LIMIT;
        end else if (i_load) begin
            r_last_read_time  <= n_last_read_time;
            r_last_write_time <= n_last_write_time;
            r_last_warn_time  <= n_last_warn_time;
            r_read_limit      <= n_read_limit;
            r_write_limit     <= n_write_limit;
            r_warn_limit      <= n_warn_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid = r_mid;

endmodule

// ===== design/hkm_out.sv =====
// Output stage: divides the new read timeout less one by three and holds the result word.
module hkm_out (
    input  logic            i_clk,
    input  logic            i_load,
    input  hkm_pkg::t_mid   i_mid,
    output hkm_pkg::t_result o_result
);
    import hkm_pkg::*;

    logic [63:0] prod;
    t_result     r_result, n_result;

    // Reciprocal multiply: the quotient sits in product bits 63 down to 33.
    assign prod = {32'd0, i_mid.div_arg} * {32'd0, DIV3_RECIP};

    always_comb begin
        n_result.deliver_up        = i_mid.deliver_up;
        n_result.send_keepalive    = i_mid.send_keepalive;
        n_result.send_timeout_ctrl = i_mid.send_timeout_ctrl;
        n_result.timeout_value     = i_mid.send_timeout_ctrl ? {1'b0, prod[63:33]} : 32'd0;
        n_result.error_code        = i_mid.error_code;
        n_result.warn_elapsed      = i_mid.warn_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ===== design/hkm_checker.sv =====
// Port-level checker for the heartbeat keepalive monitor, bound to the top level.
`include "heartbeat_keepalive_monitor_macros.svh"

module hkm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [111:0] i_s_axis_tdata,
    input logic [2:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [71:0]  o_m_axis_tdata,
    input logic         i_cfg_we,
    input logic         i_cfg_addr,
    input logic         i_cfg_wdata
);

    // Reset leaves no result word behind.
    `HKM_ASSERT_NXT(a_reset_empty, !i_rst_n, !o_m_axis_tvalid, "output valid after reset")

    // The input side only stalls when a result word is held up at the output.
    `HKM_ASSERT_IMP(a_stall_cause, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready,
        "input stalled without output backpressure")

    // A timeout value only travels with a control send, and then it is at least one.
    `HKM_ASSERT_IMP(a_ctrl_value, o_m_axis_tvalid,
        (o_m_axis_tdata[2] == 1'b1) == (o_m_axis_tdata[34:3] != 32'd0),
        "timeout value does not match control send")

    // A held result word does not change.
    `HKM_ASSERT_NXT(a_out_hold, i_rst_n && o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result word changed")

endmodule

bind heartbeat_keepalive_monitor hkm_checker u_hkm_checker (.*);
